[rtl/coefficient_quantizer_assert.svh]
// Assertion macros for the coefficient quantizer checker.
// Needs a clock and a reset signal in the scope where a macro is used.
`ifndef COEFFICIENT_QUANTIZER_ASSERT_SVH
`define COEFFICIENT_QUANTIZER_ASSERT_SVH

// implication in the same cycle, off during reset
`define CQ_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// implication into the next cycle, off during reset
`define CQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// state in the cycle after reset
`define CQ_ASSERT_AFTER_RESET(label, clk, rst, cons, msg) \
   label: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error(msg);

`endif

[rtl/cq_pkg.sv]
// Types, codes and step-size constants of the coefficient quantizer.
// No dependencies; used by the top level and the checker.
package cq_pkg;

   localparam int QP_WIDTH        = 6;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 6;
   localparam int STEP_WIDTH      = 15;
   localparam int BASE_WIDTH      = 5;
   localparam int REM_WIDTH       = 5;
   localparam int BASE_IDX_WIDTH  = 3;
   localparam int SHIFT_WIDTH     = 4;
   localparam int THIRD_WIDTH     = 13;

   localparam int STEP_PERIOD = 6;
   localparam int DIV6_MUL    = 43;
   localparam int DIV6_SHIFT  = 8;
   localparam int THIRD_MUL   = 43691;
   localparam int THIRD_SHIFT = 17;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_QUANT_PARAM = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_QUANT_MODE  = 1'b1;

   typedef enum logic {
      CMD_QUANTIZE   = 1'b0,
      CMD_DEQUANTIZE = 1'b1
   } cmd_type;

   typedef enum logic {
      MODE_SCALAR   = 1'b0,
      MODE_DEADZONE = 1'b1
   } mode_type;

   function automatic logic [BASE_WIDTH-1:0] step_base(input logic [BASE_IDX_WIDTH-1:0] idx);
      logic [BASE_WIDTH-1:0] base;
      unique case (idx)
         3'd0: base = 5'd10;
         3'd1: base = 5'd11;
         3'd2: base = 5'd13;
         3'd3: base = 5'd14;
         3'd4: base = 5'd16;
         3'd5: base = 5'd18;
         default: base = 5'd10;
      endcase
      return base;
   endfunction

endpackage

[rtl/cq_if.sv]
// Valid/ready channel interfaces of the coefficient quantizer.
// Request carries command, coefficient and last flag; response carries value and last flag.
interface cq_req_if #(parameter int COEFF_WIDTH = 16);
   logic                          valid;
   logic                          ready;
   logic                          cmd;
   logic signed [COEFF_WIDTH-1:0] coeff_in;
   logic                          last_in;

   modport source (output valid, output cmd, output coeff_in, output last_in, input ready);
   modport sink   (input valid, input cmd, input coeff_in, input last_in, output ready);
endinterface

interface cq_rsp_if #(parameter int COEFF_WIDTH = 16);
   logic                          valid;
   logic                          ready;
   logic signed [COEFF_WIDTH-1:0] value_out;
   logic                          last_out;

   modport source (output valid, output value_out, output last_out, input ready);
   modport sink   (input valid, input value_out, input last_out, output ready);
endinterface

[rtl/coefficient_quantizer.sv]
// Pipelined scalar/deadzone quantizer and dequantizer, one coefficient per transaction.
// Depends on cq_pkg and the channel interfaces in cq_if.sv.
//
//   channel   direction   handshake             payload
//   req_ch    in          valid/ready           cmd, coeff_in, last_in
//   rsp_ch    out         valid/ready           value_out, last_out
//   csr_*     in          csr_wr_en, no wait    csr_index, csr_wdata
//
// One transaction per cycle while the response is not stalled. Pipeline, with M = max(COEFF_WIDTH,15):
// four setup stages, a restoring divider by the step base at 8 bits per stage over M bits, output.
// Synchronous reset clears valid bits and both registers (qp 0, scalar mode).
// A stalled response holds the whole pipeline; req_ch.ready drops only then.
module coefficient_quantizer #(
   parameter int COEFF_WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   cq_req_if.sink                               req_ch,
   cq_rsp_if.source                             rsp_ch,
   input  logic                                 csr_wr_en,
   input  logic [cq_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [cq_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);
   import cq_pkg::*;

   localparam int SUM_WIDTH  = ((COEFF_WIDTH > STEP_WIDTH) ? COEFF_WIDTH : STEP_WIDTH) + 1;
   localparam int MAG_WIDTH  = SUM_WIDTH - 1;
   localparam int PROD_WIDTH = COEFF_WIDTH + STEP_WIDTH + 1;
   localparam int CMP_WIDTH  = (COEFF_WIDTH > THIRD_WIDTH) ? COEFF_WIDTH : THIRD_WIDTH;
   localparam int DIV_BITS   = 8;
   localparam int DIV_STAGES = (MAG_WIDTH + DIV_BITS - 1) / DIV_BITS;

   typedef struct packed {
      cmd_type                cmd;
      logic                   last;
      logic                   zero;
      logic                   neg;
      logic [COEFF_WIDTH-1:0] prod;
      logic [BASE_WIDTH-1:0]  base;
      logic [REM_WIDTH-1:0]   rem;
      logic [MAG_WIDTH-1:0]   work;
   } div_lane_type;

   logic [QP_WIDTH-1:0] qp_ff;
   mode_type            mode_ff;
   logic                advance;

   logic                          s1_valid_ff;
   cmd_type                       s1_cmd_ff;
   logic signed [COEFF_WIDTH-1:0] s1_coeff_ff;
   logic                          s1_last_ff;
   mode_type                      s1_mode_ff;
   logic [QP_WIDTH-1:0]           s1_qp_ff;

   logic [11:0]                   s1_div6;
   logic [SHIFT_WIDTH-1:0]        s1_shift_in;
   logic [QP_WIDTH-1:0]           s1_rem;
   logic [BASE_WIDTH-1:0]         s1_base_in;
   logic [STEP_WIDTH-1:0]         s1_step_in;

   logic                          s2_valid_ff;
   cmd_type                       s2_cmd_ff;
   logic signed [COEFF_WIDTH-1:0] s2_coeff_ff;
   logic                          s2_last_ff;
   mode_type                      s2_mode_ff;
   logic [STEP_WIDTH-1:0]         s2_step_ff;
   logic [SHIFT_WIDTH-1:0]        s2_shift_ff;
   logic [BASE_WIDTH-1:0]         s2_base_ff;

   logic [31:0]                   s2_third_prod;
   logic [THIRD_WIDTH-1:0]        s2_third_in;
   logic [STEP_WIDTH-1:0]         s2_addend;
   logic signed [PROD_WIDTH-1:0]  s2_prod_full;
   logic signed [SUM_WIDTH-1:0]   s2_sum;
   logic [SUM_WIDTH-1:0]          s2_sum_abs;
   logic [COEFF_WIDTH-1:0]        s2_abs_coeff_in;

   logic                          s3_valid_ff;
   cmd_type                       s3_cmd_ff;
   logic                          s3_last_ff;
   mode_type                      s3_mode_ff;
   logic [THIRD_WIDTH-1:0]        s3_third_ff;
   logic [COEFF_WIDTH-1:0]        s3_prod_ff;
   logic [MAG_WIDTH-1:0]          s3_mag_ff;
   logic                          s3_neg_ff;
   logic [COEFF_WIDTH-1:0]        s3_abs_coeff_ff;
   logic [SHIFT_WIDTH-1:0]        s3_shift_ff;
   logic [BASE_WIDTH-1:0]         s3_base_ff;

   div_lane_type                  div_entry_in;
   div_lane_type                  div_ff       [DIV_STAGES+1];
   div_lane_type                  div_in       [DIV_STAGES];
   logic                          div_valid_ff [DIV_STAGES+1];

   logic                          out_valid_ff;
   logic [COEFF_WIDTH-1:0]        out_value_ff;
   logic [COEFF_WIDTH-1:0]        out_value_in;
   logic                          out_last_ff;

   assign advance       = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready  = advance;
   assign rsp_ch.valid  = out_valid_ff;
   assign rsp_ch.value_out = out_value_ff;
   assign rsp_ch.last_out  = out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         qp_ff   <= '0;
         mode_ff <= MODE_SCALAR;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_QUANT_PARAM: qp_ff   <= csr_wdata[QP_WIDTH-1:0];
            REG_QUANT_MODE:  mode_ff <= mode_type'(csr_wdata[0]);
            default: ;
         endcase
      end
   end

   always_comb begin
      s1_div6     = 12'(s1_qp_ff) * 12'(DIV6_MUL);
      s1_shift_in = s1_div6[DIV6_SHIFT +: SHIFT_WIDTH];
      s1_rem      = s1_qp_ff - QP_WIDTH'(s1_shift_in * STEP_PERIOD);
      s1_base_in  = step_base(s1_rem[BASE_IDX_WIDTH-1:0]);
      s1_step_in  = STEP_WIDTH'(s1_base_in) << s1_shift_in;
   end

   always_comb begin
      s2_third_prod   = 32'(s2_step_ff) * 32'(THIRD_MUL);
      s2_third_in     = s2_third_prod[THIRD_SHIFT +: THIRD_WIDTH];
      s2_addend       = (s2_mode_ff == MODE_SCALAR) ? (s2_step_ff >> 1) : '0;
      s2_prod_full    = PROD_WIDTH'(s2_coeff_ff) * PROD_WIDTH'($signed({1'b0, s2_step_ff}));
      s2_sum          = SUM_WIDTH'(s2_coeff_ff) + $signed(SUM_WIDTH'(s2_addend));
      s2_sum_abs      = s2_sum[SUM_WIDTH-1] ? SUM_WIDTH'(-s2_sum) : SUM_WIDTH'(s2_sum);
      s2_abs_coeff_in = s2_coeff_ff[COEFF_WIDTH-1] ? COEFF_WIDTH'(-s2_coeff_ff)
                                                   : COEFF_WIDTH'(s2_coeff_ff);
   end

   always_comb begin
      div_entry_in.cmd  = s3_cmd_ff;
      div_entry_in.last = s3_last_ff;
      div_entry_in.zero = (s3_mode_ff == MODE_DEADZONE) &&
                          (CMP_WIDTH'(s3_abs_coeff_ff) < CMP_WIDTH'(s3_third_ff));
      div_entry_in.neg  = s3_neg_ff;
      div_entry_in.prod = s3_prod_ff;
      div_entry_in.base = s3_base_ff;
      div_entry_in.rem  = '0;
      div_entry_in.work = s3_mag_ff >> s3_shift_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         s2_valid_ff     <= 1'b0;
         s3_valid_ff     <= 1'b0;
         div_valid_ff[0] <= 1'b0;
      end else if (advance) begin
         s1_valid_ff     <= req_ch.valid;
         s2_valid_ff     <= s1_valid_ff;
         s3_valid_ff     <= s2_valid_ff;
         div_valid_ff[0] <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_cmd_ff       <= cmd_type'(req_ch.cmd);
         s1_coeff_ff     <= req_ch.coeff_in;
         s1_last_ff      <= req_ch.last_in;
         s1_mode_ff      <= mode_ff;
         s1_qp_ff        <= qp_ff;

         s2_cmd_ff       <= s1_cmd_ff;
         s2_coeff_ff     <= s1_coeff_ff;
         s2_last_ff      <= s1_last_ff;
         s2_mode_ff      <= s1_mode_ff;
         s2_step_ff      <= s1_step_in;
         s2_shift_ff     <= s1_shift_in;
         s2_base_ff      <= s1_base_in;

         s3_cmd_ff       <= s2_cmd_ff;
         s3_last_ff      <= s2_last_ff;
         s3_mode_ff      <= s2_mode_ff;
         s3_third_ff     <= s2_third_in;
         s3_prod_ff      <= s2_prod_full[COEFF_WIDTH-1:0];
         s3_mag_ff       <= s2_sum_abs[MAG_WIDTH-1:0];
         s3_neg_ff       <= s2_sum[SUM_WIDTH-1];
         s3_abs_coeff_ff <= s2_abs_coeff_in;
         s3_shift_ff     <= s2_shift_ff;
         s3_base_ff      <= s2_base_ff;

         div_ff[0]       <= div_entry_in;
      end
   end

   for (genvar d = 0; d < DIV_STAGES; d++) begin : g_div
      localparam int FIRST = d * DIV_BITS;
      localparam int NBITS = (MAG_WIDTH - FIRST > DIV_BITS) ? DIV_BITS : MAG_WIDTH - FIRST;

      always_comb begin
         div_lane_type       lane;
         logic [REM_WIDTH:0] trial;
         lane  = div_ff[d];
         trial = '0;
         for (int j = 0; j < NBITS; j++) begin
            trial     = {lane.rem, lane.work[MAG_WIDTH-1]};
            lane.work = {lane.work[MAG_WIDTH-2:0], 1'b0};
            if (trial >= {1'b0, lane.base}) begin
               trial        = trial - {1'b0, lane.base};
               lane.work[0] = 1'b1;
            end
            lane.rem = trial[REM_WIDTH-1:0];
         end
         div_in[d] = lane;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            div_valid_ff[d+1] <= 1'b0;
         end else if (advance) begin
            div_valid_ff[d+1] <= div_valid_ff[d];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            div_ff[d+1] <= div_in[d];
         end
      end
   end

   always_comb begin
      if (div_ff[DIV_STAGES].cmd == CMD_DEQUANTIZE) begin
         out_value_in = div_ff[DIV_STAGES].prod;
      end else if (div_ff[DIV_STAGES].zero) begin
         out_value_in = '0;
      end else if (div_ff[DIV_STAGES].neg) begin
         out_value_in = COEFF_WIDTH'(-div_ff[DIV_STAGES].work);
      end else begin
         out_value_in = COEFF_WIDTH'(div_ff[DIV_STAGES].work);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= div_valid_ff[DIV_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_value_ff <= out_value_in;
         out_last_ff  <= div_ff[DIV_STAGES].last;
      end
   end

endmodule

[rtl/cq_checker.sv]
// Port-level checker for the coefficient quantizer, bound to the top level.
// Depends on coefficient_quantizer_assert.svh and cq_pkg.
`include "coefficient_quantizer_assert.svh"

module cq_checker #(
   parameter int COEFF_WIDTH = 16
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [COEFF_WIDTH-1:0] rsp_value,
   input logic                   rsp_last
);
   import cq_pkg::*;

   localparam int PEND_WIDTH = 8;

   logic [PEND_WIDTH-1:0] pending_ff;
   logic [PEND_WIDTH-1:0] pending_in;
   logic                  req_fire;
   logic                  rsp_fire;

   assign req_fire   = req_valid && req_ready;
   assign rsp_fire   = rsp_valid && rsp_ready;
   assign pending_in = pending_ff + PEND_WIDTH'(req_fire) - PEND_WIDTH'(rsp_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   `CQ_ASSERT_AFTER_RESET(a_reset_empty, clock, reset, !rsp_valid, "response valid after reset")
   `CQ_ASSERT_IMPLY(a_no_spurious, clock, reset, rsp_valid, pending_ff != '0, "response without request")
   `CQ_ASSERT_IMPLY(a_ready_flow, clock, reset, rsp_ready, req_ready, "request stalled while response side free")
   `CQ_ASSERT_NEXT(a_valid_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "response valid dropped")
   `CQ_ASSERT_NEXT(a_data_hold, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_value) && $stable(rsp_last), "stalled response changed")

endmodule

bind coefficient_quantizer cq_checker #(.COEFF_WIDTH(COEFF_WIDTH)) u_cq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_value (rsp_ch.value_out),
   .rsp_last  (rsp_ch.last_out)
);

[dv/coefficient_quantizer_checker.sv]
// Checker for the coefficient quantizer: watches both channels and the register port,
// predicts each response and compares it field by field. Depends on cq_pkg and cq_if.sv.
module coefficient_quantizer_checker #(
   parameter int COEFF_WIDTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   cq_req_if                                  req_mon,
   cq_rsp_if                                  rsp_mon,
   input  logic                               csr_wr_en,
   input  logic [cq_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [cq_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   output int                                 fail_count,
   output int                                 pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import cq_pkg::*;

   localparam int STEP_BASES [STEP_PERIOD] = '{10, 11, 13, 14, 16, 18};

   typedef struct packed {
      logic [COEFF_WIDTH-1:0] value;
      logic                   last;
   } coeff_result_type;

   coeff_result_type    result_q [$];
   logic [QP_WIDTH-1:0] qp_reg = '0;
   mode_type            mode_reg = MODE_SCALAR;

   function automatic logic [COEFF_WIDTH-1:0] scale_coeff(
      input cmd_type                       cmd,
      input logic signed [COEFF_WIDTH-1:0] coeff,
      input logic [QP_WIDTH-1:0]           qp,
      input mode_type                      mode
   );
      longint step;
      longint c;
      longint mag;
      longint r;
      step = STEP_BASES[qp % STEP_PERIOD];
      step = step << (qp / STEP_PERIOD);
      c = coeff;
      if (cmd == CMD_DEQUANTIZE) begin
         r = c * step;
      end else if (mode == MODE_SCALAR) begin
         r = (c + step / 2) / step;
      end else begin
         mag = (c < 0) ? -c : c;
         r = (mag < step / 3) ? 0 : c / step;
      end
      return r[COEFF_WIDTH-1:0];
   endfunction

   always @(posedge clock) begin
      coeff_result_type got;
      coeff_result_type want;
      int errs;
      errs = 0;
      if (reset) begin
         result_q.delete();
         qp_reg <= '0;
         mode_reg <= MODE_SCALAR;
         fail_count <= 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.value = rsp_mon.value_out;
            got.last  = rsp_mon.last_out;
            if (result_q.size() == 0) begin
               $error("unexpected response: value_out %0d, last_out %0b",
                      $signed(got.value), got.last);
               errs++;
            end else begin
               want = result_q.pop_front();
               if (got.value !== want.value) begin
                  $error("value_out mismatch: expected %0d, actual %0d",
                         $signed(want.value), $signed(got.value));
                  errs++;
               end
               if (got.last !== want.last) begin
                  $error("last_out mismatch: expected %0b, actual %0b", want.last, got.last);
                  errs++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            want.value = scale_coeff(cmd_type'(req_mon.cmd), req_mon.coeff_in, qp_reg, mode_reg);
            want.last  = req_mon.last_in;
            result_q.push_back(want);
         end
         if (csr_wr_en) begin
            if (csr_index == REG_QUANT_PARAM)
               qp_reg <= csr_wdata[QP_WIDTH-1:0];
            else
               mode_reg <= mode_type'(csr_wdata[0]);
         end
         fail_count <= fail_count + errs;
      end
      pending_count <= result_q.size();
   end

endmodule

[dv/testbench.sv]
// Top of the coefficient quantizer testbench: clock, reset, register settings and traffic.
// Depends on cq_pkg, cq_if.sv, the block and coefficient_quantizer_checker.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import cq_pkg::*;

   localparam int COEFF_WIDTH      = 16;
   localparam int PHASES           = 10;
   localparam int ITEMS_PER_PHASE  = 125;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int IDLE_LIMIT       = 5000;
   localparam int SETTLE_CYCLES    = 20;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       csr_wr_en;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata;
   int                         fail_count;
   int                         pending_count;
   logic                       long_hold = 1'b0;
   int                         idle_cycles = 0;

   cq_req_if #(.COEFF_WIDTH(COEFF_WIDTH)) req_ch ();
   cq_rsp_if #(.COEFF_WIDTH(COEFF_WIDTH)) rsp_ch ();

   coefficient_quantizer #(.COEFF_WIDTH(COEFF_WIDTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   coefficient_quantizer_checker #(.COEFF_WIDTH(COEFF_WIDTH)) checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL coefficient_quantizer");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int style;
      int span;
      style = 0;
      span = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            long_hold = 1'b0;
         end
         if (span == 0) begin
            style = $urandom_range(0, 3);
            span = $urandom_range(16, 96);
         end
         span--;
         case (style)
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= $urandom_range(0, 1);
            2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ch.ready <= (span % 3 != 0);
         endcase
      end
   end

   task automatic offer_coeff(input cmd_type cmd, input int coeff, input logic last);
      req_ch.valid    <= 1'b1;
      req_ch.cmd      <= cmd;
      req_ch.coeff_in <= coeff[COEFF_WIDTH-1:0];
      req_ch.last_in  <= last;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic pause_sender(input int cycles);
      req_ch.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   task automatic apply_setting(input logic [QP_WIDTH-1:0] qp, input mode_type mode);
      csr_wr_en <= 1'b1;
      csr_index <= REG_QUANT_PARAM;
      csr_wdata <= CSR_DATA_WIDTH'(qp);
      @(posedge clock);
      csr_index <= REG_QUANT_MODE;
      csr_wdata <= CSR_DATA_WIDTH'(mode);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic int pick_coeff();
      int mag;
      case ($urandom_range(0, 5))
         0, 1: return $urandom_range(0, 65535) - 32768;
         2: mag = $urandom_range(0, 64);
         3: mag = $urandom_range(0, 4096);
         4: mag = $urandom_range(0, 16384);
         default: begin
            case ($urandom_range(0, 2))
               0: return 32767;
               1: return -32768;
               default: return 0;
            endcase
         end
      endcase
      return $urandom_range(0, 1) ? -mag : mag;
   endfunction

   initial begin
      logic [QP_WIDTH-1:0] qp;
      mode_type            mode;
      bit                  gapless;
      int                  burst_left;
      int                  gap;
      reset           <= 1'b1;
      csr_wr_en       <= 1'b0;
      csr_index       <= REG_QUANT_PARAM;
      csr_wdata       <= '0;
      req_ch.valid    <= 1'b0;
      req_ch.cmd      <= CMD_QUANTIZE;
      req_ch.coeff_in <= '0;
      req_ch.last_in  <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      offer_coeff(CMD_QUANTIZE, 0, 1'b0);
      offer_coeff(CMD_QUANTIZE, 32767, 1'b0);
      offer_coeff(CMD_QUANTIZE, -32768, 1'b1);
      offer_coeff(CMD_QUANTIZE, -5, 1'b0);
      offer_coeff(CMD_QUANTIZE, 4, 1'b0);
      offer_coeff(CMD_DEQUANTIZE, 32767, 1'b0);
      offer_coeff(CMD_DEQUANTIZE, -32768, 1'b0);
      offer_coeff(CMD_DEQUANTIZE, -3, 1'b1);
      drain_results();
      apply_setting(6'd51, MODE_DEADZONE);
      offer_coeff(CMD_QUANTIZE, 32767, 1'b0);
      offer_coeff(CMD_QUANTIZE, -32768, 1'b0);
      offer_coeff(CMD_QUANTIZE, 1535, 1'b0);
      offer_coeff(CMD_QUANTIZE, 1536, 1'b0);
      offer_coeff(CMD_QUANTIZE, -1535, 1'b0);
      offer_coeff(CMD_QUANTIZE, -1536, 1'b1);
      offer_coeff(CMD_DEQUANTIZE, 7, 1'b0);
      drain_results();
      apply_setting(6'd63, MODE_SCALAR);
      offer_coeff(CMD_QUANTIZE, 32767, 1'b0);
      offer_coeff(CMD_QUANTIZE, -32768, 1'b0);
      offer_coeff(CMD_QUANTIZE, 7168, 1'b0);
      offer_coeff(CMD_QUANTIZE, 7167, 1'b0);
      offer_coeff(CMD_QUANTIZE, -7168, 1'b0);
      offer_coeff(CMD_DEQUANTIZE, 2, 1'b0);
      offer_coeff(CMD_DEQUANTIZE, -3, 1'b1);

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin qp = 6'd0;  mode = MODE_DEADZONE; end
            1: begin qp = 6'd63; mode = MODE_DEADZONE; end
            2: begin qp = 6'd51; mode = MODE_SCALAR;   end
            3: begin qp = 6'd0;  mode = MODE_SCALAR;   end
            default: begin
               qp = $urandom_range(0, 63);
               mode = mode_type'($urandom_range(0, 1));
            end
         endcase
         drain_results();
         apply_setting(qp, mode);
         gapless = (phase == 3) || ($urandom_range(0, 3) == 0);
         burst_left = 0;
         if (phase == 3)
            long_hold = 1'b1;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (phase == 6 && n == ITEMS_PER_PHASE / 2)
               drain_results();
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 40);
               gap = gapless ? 0 : $urandom_range(0, 6);
               if (gap > 0)
                  pause_sender(gap);
            end
            burst_left--;
            offer_coeff(cmd_type'($urandom_range(0, 1)), pick_coeff(),
                        $urandom_range(0, 7) == 0);
         end
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("PASS coefficient_quantizer");
      else
         $display("FAIL coefficient_quantizer");
      $finish;
   end

endmodule
